// File: rtl/msqt_pkg.sv
// Shared types and constants for the millisecond sleep queue timer.
`timescale 1ns / 1ps

package msqt_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned IdW   = 8;

    typedef struct packed {
        logic             kind;
        logic [IdW-1:0]   proc_id;
        logic [TimeW-1:0] duration_ms;
    } t_req;

    typedef struct packed {
        logic             woken_valid;
        logic [IdW-1:0]   woken_id;
        logic             reschedule;
        logic             queue_full;
        logic [TimeW-1:0] now_ms;
    } t_rsp;

    typedef struct packed {
        logic [TimeW-1:0] wake;
        logic [IdW-1:0]   id;
    } t_entry;

    localparam logic KindTick  = 1'b0;
    localparam logic KindSleep = 1'b1;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [TimeW-1:0] a;
        logic [TimeW-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [TimeW-1:0] sum;
        logic             lt;
    } t_alu_rsp;

endpackage

// File: rtl/msqt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module msqt_ram #(
    parameter int unsigned WIDTH = 40,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/msqt_alu.sv
// Shared 32-bit add / subtract-compare unit.
`timescale 1ns / 1ps

module msqt_alu (
    input  msqt_pkg::t_alu_req i_alu_req,
    output msqt_pkg::t_alu_rsp o_alu_rsp
);

    logic                     sub;
    logic [msqt_pkg::TimeW:0] sum;

    assign sub = (i_alu_req.op == msqt_pkg::ALU_SUB);

    always_comb begin
        sum = {1'b0, i_alu_req.a}
            + {1'b0, (sub ? ~i_alu_req.b : i_alu_req.b)}
            + {{msqt_pkg::TimeW{1'b0}}, sub};
        o_alu_rsp.sum = sum[msqt_pkg::TimeW-1:0];
        o_alu_rsp.lt  = sub & ~sum[msqt_pkg::TimeW];
    end

endmodule

// File: rtl/millisecond_sleep_queue_timer_unit.sv
// Top level: millisecond timestamp and sorted sleep queue sequencer.
//
// channel | dir | handshake                    | payload
// request | in  | i_req_valid / o_req_stall    | i_req (kind, proc_id, duration_ms)
// result  | out | o_rsp_valid / i_rsp_stall    | o_rsp (woken, id, flags, now_ms)
//
// One request at a time; a tick on an empty queue finishes without a RAM read,
// otherwise it reads and compares the head. A sleep is dropped when the queue is full,
// else it moves entries back until it lands at the front or a compare stops it,
// passing at most QUEUE_DEPTH - 1 entries; the RAM read-compare-write loop does this.
// Reset is synchronous; no clearing pass, the queue is empty after reset.
// A stalled result does not block the next request; the sequencer then waits in S_DONE until it is taken.
`timescale 1ns / 1ps

module millisecond_sleep_queue_timer_unit #(
    parameter int unsigned QUEUE_DEPTH      = 16,
    parameter int unsigned TICKS_PER_SECOND = 1000
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  msqt_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output msqt_pkg::t_rsp o_rsp
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned MW = $clog2(TICKS_PER_SECOND);
    localparam int unsigned EW = $bits(msqt_pkg::t_entry);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_ADD      = 6'b000010,
        S_HEAD_RD  = 6'b000100,
        S_HEAD_CMP = 6'b001000,
        S_INS_RD   = 6'b010000,
        S_INS_CMP  = 6'b100000
    } t_state;

    localparam t_state S_DONE = S_IDLE;

    t_state                       r_state, n_state;
    logic                         r_done, n_done;
    logic [msqt_pkg::TimeW-1:0]   r_now, n_now;
    logic [MW-1:0]                r_ms, n_ms;
    logic [CW-1:0]                r_count, n_count;
    logic [AW-1:0]                r_head, n_head;
    logic [CW-1:0]                r_pos, n_pos;
    msqt_pkg::t_req               r_req, n_req;
    logic [msqt_pkg::TimeW-1:0]   r_sum, n_sum;
    logic                         r_woken, n_woken;
    logic [msqt_pkg::IdW-1:0]     r_wid, n_wid;
    logic                         r_full, n_full;
    logic                         r_rsp_valid, n_rsp_valid;
    msqt_pkg::t_rsp               r_rsp, n_rsp;

    msqt_pkg::t_alu_req alu_req;
    msqt_pkg::t_alu_rsp alu_rsp;
    msqt_pkg::t_entry   rd_entry;
    msqt_pkg::t_entry   wr_entry;
    logic [EW-1:0]      rd_bits;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr;
    logic               accept;
    logic               tick;
    logic               out_free;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [CW:0] s;
        s = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, idx};
        if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
            s = s - (CW + 1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    msqt_alu u_alu (
        .i_alu_req (alu_req),
        .o_alu_rsp (alu_rsp)
    );

    msqt_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_entry),
        .i_raddr (raddr),
        .o_rdata (rd_bits)
    );

    assign rd_entry    = msqt_pkg::t_entry'(rd_bits);
    assign accept      = i_req_valid && !o_req_stall;
    assign tick        = (r_req.kind == msqt_pkg::KindTick);
    assign out_free    = !r_rsp_valid || !i_rsp_stall;
    assign o_req_stall = (r_state != S_IDLE) || r_done;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        n_state     = r_state;
        n_done      = r_done;
        n_now       = r_now;
        n_ms        = r_ms;
        n_count     = r_count;
        n_head      = r_head;
        n_pos       = r_pos;
        n_req       = r_req;
        n_sum       = r_sum;
        n_woken     = r_woken;
        n_wid       = r_wid;
        n_full      = r_full;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        n_rsp       = r_rsp;
        alu_req.op  = msqt_pkg::ALU_ADD;
        alu_req.a   = r_now;
        alu_req.b   = r_req.duration_ms;
        we          = 1'b0;
        waddr       = phys(r_head, r_pos);
        raddr       = phys(r_head, r_pos - CW'(1));
        wr_entry.wake = r_sum;
        wr_entry.id   = r_req.proc_id;

        unique case (r_state)
            S_IDLE: begin
                if (r_done) begin
                    if (out_free) begin
                        n_done                = 1'b0;
                        n_rsp_valid           = 1'b1;
                        n_rsp.woken_valid     = r_woken;
                        n_rsp.woken_id        = r_woken ? r_wid : '0;
                        n_rsp.queue_full      = r_full;
                        if (tick) begin
                            n_now                = r_sum;
                            n_rsp.now_ms         = r_sum;
                            if (r_ms == MW'(TICKS_PER_SECOND - 1)) begin
                                n_ms             = '0;
                                n_rsp.reschedule = 1'b1;
                            end else begin
                                n_ms             = r_ms + MW'(1);
                                n_rsp.reschedule = 1'b0;
                            end
                        end else begin
                            n_rsp.now_ms     = r_now;
                            n_rsp.reschedule = 1'b1;
                        end
                    end
                end else if (accept) begin
                    n_req   = i_req;
                    n_woken = 1'b0;
                    n_wid   = '0;
                    n_full  = 1'b0;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (!tick) begin
                    alu_req.b = r_req.duration_ms;
                end else begin
                    alu_req.b = msqt_pkg::TimeW'(1);
                end
                n_sum = alu_rsp.sum;
                n_pos = r_count;
                if (!tick) begin
                    if (r_count == CW'(QUEUE_DEPTH)) begin
                        n_full  = 1'b1;
                        n_done  = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_INS_RD;
                    end
                end else if (r_count == '0) begin
                    n_done  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                raddr   = r_head;
                n_state = S_HEAD_CMP;
            end
            S_HEAD_CMP: begin
                alu_req.op = msqt_pkg::ALU_SUB;
                alu_req.a  = r_now;
                alu_req.b  = rd_entry.wake;
                if (!alu_rsp.lt) begin
                    n_woken = 1'b1;
                    n_wid   = rd_entry.id;
                    n_count = r_count - CW'(1);
                    n_head  = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
                end
                n_done  = 1'b1;
                n_state = S_DONE;
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                    n_done  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                alu_req.op = msqt_pkg::ALU_SUB;
                alu_req.a  = r_sum;
                alu_req.b  = rd_entry.wake;
                we         = 1'b1;
                if (alu_rsp.lt) begin
                    wr_entry = rd_entry;
                    n_pos    = r_pos - CW'(1);
                    n_state  = S_INS_RD;
                end else begin
                    n_count = r_count + CW'(1);
                    n_done  = 1'b1;
                    n_state = S_DONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_now       <= '0;
            r_ms        <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_now       <= n_now;
            r_ms        <= n_ms;
            r_count     <= n_count;
            r_head      <= n_head;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_req   <= n_req;
        r_sum   <= n_sum;
        r_woken <= n_woken;
        r_wid   <= n_wid;
        r_full  <= n_full;
        r_rsp   <= n_rsp;
    end

endmodule

// File: rtl/msqt_checker.sv
// Port-level assertions for the sleep queue timer, bound to the top level.
`timescale 1ns / 1ps

module msqt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_stall,
    input logic           i_rsp_valid,
    input logic           i_rsp_stall,
    input msqt_pkg::t_rsp i_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_stall |=> i_rsp_valid && $stable(i_rsp))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !i_req_stall |=> i_req_stall)
        else $error("request taken while previous one in flight");

    a_wake_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.woken_valid |-> !i_rsp.queue_full)
        else $error("wakeup and full flagged together");

    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp.woken_valid |-> i_rsp.woken_id == '0)
        else $error("woken id without wakeup");

    a_full_resched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.queue_full |-> i_rsp.reschedule)
        else $error("dropped sleep without reschedule");

endmodule

bind millisecond_sleep_queue_timer_unit msqt_checker u_msqt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .i_req_stall (o_req_stall),
    .i_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .i_rsp       (o_rsp)
);
